FILE: hw/rtl/scfp_pkg.sv
// Shared constants and types of the serial-to-CAN frame parser.
`timescale 1ns / 1ps

package scfp_pkg;

   // Frame layout.
   localparam int STAMP_OFFSET   = 0;
   localparam int ID_OFFSET      = 4;
   localparam int LENGTH_OFFSET  = 8;
   localparam int PAYLOAD_OFFSET = 9;
   localparam int MAX_PAYLOAD    = 8;
   localparam int STORE_DEPTH    = 32;

   // Derived sizes.
   localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
   localparam int POS_W       = $clog2(PAYLOAD_OFFSET + MAX_PAYLOAD + 1);
   localparam int LEN_W       = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 2;

   // Register reset values.
   localparam logic [7:0] START_TOKEN_RESET = 8'd2;
   localparam logic [7:0] END_TOKEN_RESET   = 8'd3;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_TOKEN = 2'd0,
      CSR_END_TOKEN   = 2'd1
   } csr_index_type;

   // Parser phase.
   typedef enum logic {
      PHASE_IDLE  = 1'b0,
      PHASE_FRAME = 1'b1
   } phase_type;

   // One classified frame handed from the front to the back.
   typedef struct packed {
      logic             ok;
      logic [31:0]      frame_id;
      logic [31:0]      time_stamp;
      logic [LEN_W-1:0] length;
      logic [63:0]      payload;
   } frame_cmd_type;

   // Queue status seen by the front.
   typedef struct packed {
      logic full;
   } queue_status_type;

endpackage

FILE: hw/rtl/scfp_front.sv
// Front end: token registers, byte parser, frame store and frame classification.
`timescale 1ns / 1ps

module scfp_front
   import scfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data,
   input  queue_status_type     q_status,
   output logic                 push_valid,
   output frame_cmd_type        push_cmd
);

   logic [7:0]             start_tok_ff;
   logic [7:0]             end_tok_ff;
   phase_type              phase_ff, phase_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [7:0]             store_ff [STORE_DEPTH];
   logic                   store_we;
   logic [STORE_IDX_W-1:0] wr_addr;
   logic                   accept;
   logic [LEN_W-1:0]       len_eff;
   logic                   oversize;
   logic [31:0]            snap_id;
   logic [31:0]            snap_stamp;
   logic [63:0]            snap_payload;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign wr_addr   = STORE_IDX_W'(pos_ff);

   // Store entries beyond the depth read as zero.
   function automatic logic [7:0] store_byte(input int p);
      logic [7:0] val;
      val = 8'd0;
      if (p < STORE_DEPTH) begin
         val = store_ff[p[STORE_IDX_W-1:0]];
      end
      return val;
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_tok_ff <= START_TOKEN_RESET;
         end_tok_ff   <= END_TOKEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_TOKEN: start_tok_ff <= csr_data;
            CSR_END_TOKEN:   end_tok_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
      end
   end

   // Frame store; its contents are only meaningful once written.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[wr_addr] <= req_rx_byte;
      end
   end

   // Snapshot of the fixed frame fields, read at their own positions.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         snap_id[8*k +: 8]    = store_byte(ID_OFFSET + k);
         snap_stamp[8*k +: 8] = store_byte(STAMP_OFFSET + k);
      end
      for (int k = 0; k < 8; k++) begin
         if (k < MAX_PAYLOAD) begin
            snap_payload[8*k +: 8] = store_byte(PAYLOAD_OFFSET + k);
         end else begin
            snap_payload[8*k +: 8] = 8'd0;
         end
      end
   end

   // Next state and classification of each accepted byte.
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      store_we   = 1'b0;
      push_valid = 1'b0;
      len_eff    = len_ff;
      oversize   = 1'b0;
      push_cmd   = '{ok: 1'b0, frame_id: snap_id, time_stamp: snap_stamp,
                     length: len_ff, payload: snap_payload};
      if (accept) begin
         case (phase_ff)
            PHASE_IDLE: begin
               if (req_rx_byte == start_tok_ff) begin
                  phase_in = PHASE_FRAME;
                  pos_in   = '0;
                  len_in   = '0;
               end
            end
            PHASE_FRAME: begin
               // The length byte takes effect in the cycle it arrives.
               if (int'(pos_ff) == LENGTH_OFFSET) begin
                  if (int'(req_rx_byte) > MAX_PAYLOAD) begin
                     oversize = 1'b1;
                  end else begin
                     len_eff = req_rx_byte[LEN_W-1:0];
                  end
               end
               if (oversize) begin
                  phase_in   = PHASE_IDLE;
                  push_valid = 1'b1;
               end else if (int'(pos_ff) < PAYLOAD_OFFSET + int'(len_eff)) begin
                  store_we = (int'(pos_ff) < STORE_DEPTH);
                  pos_in   = pos_ff + POS_W'(1);
                  len_in   = len_eff;
               end else begin
                  phase_in        = PHASE_IDLE;
                  push_valid      = 1'b1;
                  push_cmd.ok     = (req_rx_byte == end_tok_ff);
                  push_cmd.length = len_eff;
               end
            end
            default: phase_in = PHASE_IDLE;
         endcase
      end
   end

endmodule

FILE: hw/rtl/scfp_queue.sv
// Short queue of classified frames between the front and the back.
`timescale 1ns / 1ps

module scfp_queue
   import scfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  frame_cmd_type    push_cmd,
   output queue_status_type status,
   output logic             pop_valid,
   input  logic             pop_ready,
   output frame_cmd_type    pop_cmd
);

   frame_cmd_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign status.full = (int'(count_ff) == QUEUE_DEPTH);
   assign pop_valid   = (count_ff != '0);
   assign pop_cmd     = entry_ff[rd_ptr_ff];
   assign do_push     = push_valid && !status.full;
   assign do_pop      = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hw/rtl/scfp_back.sv
// Back end: formats queued frames into results and holds the output register.
`timescale 1ns / 1ps

module scfp_back
   import scfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  frame_cmd_type    pop_cmd,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_frame_ok,
   output logic [31:0]      rsp_frame_id,
   output logic [31:0]      rsp_time_stamp,
   output logic [LEN_W-1:0] rsp_payload_length,
   output logic [63:0]      rsp_payload_data
);

   logic             valid_ff, valid_in;
   logic             ok_ff;
   logic [31:0]      id_ff, id_in;
   logic [31:0]      stamp_ff, stamp_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [63:0]      data_ff, data_in;
   logic             load;

   assign load      = !valid_ff || !rsp_stall;
   assign pop_ready = load;
   assign valid_in  = pop_valid;

   // A rejected frame carries zeros; payload bytes past the length are cleared.
   always_comb begin
      id_in    = '0;
      stamp_in = '0;
      len_in   = '0;
      data_in  = '0;
      if (pop_cmd.ok) begin
         id_in    = pop_cmd.frame_id;
         stamp_in = pop_cmd.time_stamp;
         len_in   = pop_cmd.length;
         for (int i = 0; i < 8; i++) begin
            if (i < int'(pop_cmd.length)) begin
               data_in[8*i +: 8] = pop_cmd.payload[8*i +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff    <= pop_cmd.ok;
         id_ff    <= id_in;
         stamp_ff <= stamp_in;
         len_ff   <= len_in;
         data_ff  <= data_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_frame_ok       = ok_ff;
   assign rsp_frame_id       = id_ff;
   assign rsp_time_stamp     = stamp_ff;
   assign rsp_payload_length = len_ff;
   assign rsp_payload_data   = data_ff;

endmodule

FILE: hw/rtl/serial_to_can_frame_parser_unit.sv
// Top level of the serial-to-CAN frame parser.
//
//  Channel  Direction  Handshake           Carries
//  req      in         req_valid/stall     one serial byte
//  rsp      out        rsp_valid/stall     one frame result or rejection
//  csr      in         csr_valid/ready     start and end token writes
//
// One byte is taken every cycle while req_stall is low. The result of the byte
// that closes or rejects a frame goes to the queue, then the output register.
// req_stall rises only while the two-entry frame queue is full, which happens
// when rsp_stall holds results back. Reset restores the tokens to 2 and 3 and
// sends the parser idle; the frame store is not cleared.
`timescale 1ns / 1ps

module serial_to_can_frame_parser_unit
   import scfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_frame_ok,
   output logic [31:0]          rsp_frame_id,
   output logic [31:0]          rsp_time_stamp,
   output logic [LEN_W-1:0]     rsp_payload_length,
   output logic [63:0]          rsp_payload_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data
);

   queue_status_type q_status;
   logic             push_valid;
   frame_cmd_type    push_cmd;
   logic             pop_valid;
   logic             pop_ready;
   frame_cmd_type    pop_cmd;

   scfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   scfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .status     (q_status),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   scfp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_cmd            (pop_cmd),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_frame_id       (rsp_frame_id),
      .rsp_time_stamp     (rsp_time_stamp),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_data   (rsp_payload_data)
   );

endmodule

FILE: hw/rtl/scfp_checker.sv
// Port-level checks of the frame parser, bound to the top level.
`timescale 1ns / 1ps

module scfp_checker
   import scfp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_frame_ok,
   input logic [31:0]      rsp_frame_id,
   input logic [31:0]      rsp_time_stamp,
   input logic [LEN_W-1:0] rsp_payload_length,
   input logic [63:0]      rsp_payload_data
);

   // A stalled result stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_ok)
         && $stable(rsp_frame_id) && $stable(rsp_payload_data))
      else $error("stalled result changed");

   // Nothing comes out right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A rejected frame carries zeros in every field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_ok |-> rsp_frame_id == 32'd0 && rsp_time_stamp == 32'd0
         && rsp_payload_length == '0 && rsp_payload_data == 64'd0)
      else $error("rejected frame has nonzero fields");

   // An accepted frame never declares more than the maximum payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> int'(rsp_payload_length) <= MAX_PAYLOAD)
      else $error("payload length above maximum");

   // Payload bytes past the declared length are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |->
         (rsp_payload_data >> {rsp_payload_length, 3'b000}) == 64'd0)
      else $error("payload bytes beyond length not cleared");

endmodule

bind serial_to_can_frame_parser_unit scfp_checker u_checker (.*);
